// ===== rtl/utjt_pkg.sv =====
// Shared types, constants and byte encoders for the UTF-8 / modified UTF-8 transcoder.
package utjt_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [20:0] PLANE_BASE   = 21'h010000;
    localparam logic [20:0] CODE_LIMIT   = 21'h110000;
    localparam logic [20:0] SURR_LO      = 21'h00D800;
    localparam logic [20:0] SURR_END     = 21'h00E000;
    localparam logic [7:0]  SURR_LEAD    = 8'hED;
    localparam logic [3:0]  SURR_HI_TAG  = 4'hA;
    localparam logic [3:0]  SURR_LO_TAG  = 4'hB;
    localparam logic [7:0]  NUL_LEAD     = 8'hC0;
    localparam logic [7:0]  NUL_TRAIL    = 8'h80;

    // One unit of work handed from the front to the back
    typedef struct packed {
        logic        pre_valid;   // flush a held surrogate first
        logic [15:0] pre_code;
        logic        main_valid;
        logic        main_java;   // encode in modified form rather than standard
        logic [20:0] main_code;
        logic        last;
        logic        bad;
    } job_t;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [5:0][7:0] bytes;
    } enc_t;

    function automatic enc_t encode_utf8(logic [20:0] c);
        enc_t e;
        e = '0;
        if (c < 21'h80) begin
            e.cnt      = 3'd1;
            e.bytes[0] = c[7:0];
        end else if (c < 21'h800) begin
            e.cnt      = 3'd2;
            e.bytes[0] = {3'b110, c[10:6]};
            e.bytes[1] = {2'b10, c[5:0]};
        end else if (c < PLANE_BASE) begin
            e.cnt      = 3'd3;
            e.bytes[0] = {4'b1110, c[15:12]};
            e.bytes[1] = {2'b10, c[11:6]};
            e.bytes[2] = {2'b10, c[5:0]};
        end else if (c < CODE_LIMIT) begin
            e.cnt      = 3'd4;
            e.bytes[0] = {5'b11110, c[20:18]};
            e.bytes[1] = {2'b10, c[17:12]};
            e.bytes[2] = {2'b10, c[11:6]};
            e.bytes[3] = {2'b10, c[5:0]};
        end
        return e;
    endfunction

    function automatic enc_t encode_java(logic [20:0] c);
        enc_t        e;
        logic [20:0] d;
        e = '0;
        d = c - PLANE_BASE;
        if (c == 21'd0) begin
            e.cnt      = 3'd2;
            e.bytes[0] = NUL_LEAD;
            e.bytes[1] = NUL_TRAIL;
        end else if (c < 21'h800) begin
            e = encode_utf8(c);
        end else if (c < SURR_LO || (c >= SURR_END && c < PLANE_BASE)) begin
            e = encode_utf8(c);
        end else if (c < CODE_LIMIT) begin
            // split into a high and a low surrogate triple
            e.cnt      = 3'd6;
            e.bytes[0] = SURR_LEAD;
            e.bytes[1] = {SURR_HI_TAG, d[19:16]};
            e.bytes[2] = {2'b10, d[15:10]};
            e.bytes[3] = SURR_LEAD;
            e.bytes[4] = {SURR_LO_TAG, d[9:6]};
            e.bytes[5] = {2'b10, d[5:0]};
        end
        return e;
    endfunction

endpackage

// ===== rtl/utf8_java_utf8_transcoder.sv =====
// A byte's job is queued, then its output bytes are registered at the emitter output.
// Throughput: one source byte per cycle while in_stall is low; the emitter gives one output
// byte per cycle while out_stall is low, so a byte that yields more than one output byte
// holds the emitter, and a four-entry job queue absorbs the difference before in_stall rises.
// Reset: direction returns to UTF-8 to modified form, decode state and queue empty,
// no output pending.
module utf8_java_utf8_transcoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic       bad_coding
);
    import utjt_pkg::*;

    job_t front_job;
    job_t head_job;
    logic take;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign take      = in_valid && !q_full;

    utjt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .push      (push),
        .job       (front_job)
    );

    utjt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_job),
        .pop       (pop),
        .pop_data  (head_job),
        .empty     (q_empty),
        .full      (q_full)
    );

    utjt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_job),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .string_end (string_end),
        .bad_coding (bad_coding)
    );

    // no job is pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
        else $error("job pushed into full queue");

    // no job is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_empty)
        else $error("job popped from empty queue");

    // a bare end marker always closes a string
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid && !byte_valid) |-> string_end)
        else $error("bare marker without string end");

    // the error flag only appears on results of the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid && bad_coding && !string_end) |=> out_valid)
        else $error("error flag outside final results");

endmodule

// ===== rtl/utjt_front.sv =====
// Front end: takes source bytes, decodes sequences and issues encode jobs.
module utjt_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  logic           cfg_data,
    input  logic           take,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    output logic           push,
    output utjt_pkg::job_t job
);
    import utjt_pkg::*;

    logic        dir_reg;
    logic [7:0]  lead_reg,  lead_next;
    logic [2:0]  cnt_reg,   cnt_next;
    logic [20:0] part_reg,  part_next;
    logic [15:0] held_reg,  held_next;
    logic        pend_reg,  pend_next;
    logic [1:0]  pair_reg,  pair_next;
    logic        stop_reg,  stop_next;
    logic        sbad_reg,  sbad_next;

    always_comb
    begin
        logic       seq_go;
        logic       bad_v;
        logic [2:0] cnt1;
        logic [2:0] need;

        lead_next = lead_reg;
        cnt_next  = cnt_reg;
        part_next = part_reg;
        held_next = held_reg;
        pend_next = pend_reg;
        pair_next = pair_reg;
        stop_next = stop_reg;
        sbad_next = sbad_reg;
        job       = '0;
        job.last  = in_last;
        seq_go    = 1'b0;
        bad_v     = 1'b0;
        cnt1      = '0;
        need      = '0;

        if (!stop_reg)
        begin
            if (dir_reg && pair_reg != 2'd0)
            begin
                // second triple of a surrogate pair
                part_next = {part_reg[14:0], in_byte[5:0]};
                pair_next = pair_reg + 2'd1;
                if (pair_next == 2'd3)
                begin
                    job.main_valid = 1'b1;
                    job.main_code  = PLANE_BASE + {1'b0, held_reg[9:0], part_next[9:0]};
                    pair_next      = 2'd0;
                end
            end
            else if (dir_reg && pend_reg)
            begin
                pend_next = 1'b0;
                if (in_byte[7:4] == 4'hE)
                begin
                    part_next = {17'd0, in_byte[3:0]};
                    pair_next = 2'd1;
                end
                else
                begin
                    job.pre_valid = 1'b1;
                    job.pre_code  = held_reg;
                    seq_go        = 1'b1;
                end
            end
            else
            begin
                seq_go = 1'b1;
            end

            if (seq_go)
            begin
                if (cnt_reg == 3'd0)
                begin
                    lead_next = in_byte;
                    if (!in_byte[7])
                    begin
                        job.main_valid = 1'b1;
                        job.main_java  = !dir_reg;
                        job.main_code  = {13'd0, in_byte};
                    end
                    else
                    begin
                        cnt_next = 3'd1;
                        if (in_byte[7:5] == 3'b110)
                        begin
                            part_next = {16'd0, in_byte[4:0]};
                            sbad_next = 1'b0;
                        end
                        else
                        begin
                            part_next = {17'd0, in_byte[3:0]};
                            if (dir_reg)
                                sbad_next = in_byte[7:4] != 4'hE;
                            else
                                sbad_next = in_byte[7:4] != 4'hE && in_byte[7:3] != 5'b11110;
                        end
                    end
                end
                else
                begin
                    bad_v     = sbad_reg | (in_byte[7:6] != 2'b10);
                    part_next = {part_reg[14:0], in_byte[5:0]};
                    cnt1      = cnt_reg + 3'd1;
                    priority if (lead_reg[7:5] == 3'b110)
                        need = 3'd2;
                    else if (dir_reg || lead_reg[7:4] == 4'hE)
                        need = 3'd3;
                    else
                        need = 3'd4;
                    if (cnt1 >= need)
                    begin
                        cnt_next  = 3'd0;
                        sbad_next = 1'b0;
                        priority if (bad_v)
                            stop_next = 1'b1;
                        else if (!dir_reg)
                        begin
                            job.main_valid = 1'b1;
                            job.main_java  = 1'b1;
                            job.main_code  = part_next;
                        end
                        else if (need == 3'd3 && part_next[15:11] == 5'b11011)
                        begin
                            // hold the surrogate until the next byte shows a partner
                            held_next = part_next[15:0];
                            pend_next = 1'b1;
                        end
                        else
                        begin
                            job.main_valid = 1'b1;
                            job.main_code  = part_next;
                        end
                    end
                    else
                    begin
                        cnt_next  = cnt1;
                        sbad_next = bad_v;
                    end
                end
            end

            if (in_last && pend_next && !stop_next)
            begin
                job.main_valid = 1'b1;
                job.main_java  = 1'b0;
                job.main_code  = {5'd0, held_next};
                pend_next      = 1'b0;
            end
        end

        job.bad = stop_next;

        if (in_last)
        begin
            lead_next = '0;
            cnt_next  = '0;
            part_next = '0;
            held_next = '0;
            pend_next = 1'b0;
            pair_next = '0;
            stop_next = 1'b0;
            sbad_next = 1'b0;
        end
    end

    assign push = take && (job.pre_valid || job.main_valid || in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b0;
            lead_reg <= '0;
            cnt_reg  <= '0;
            part_reg <= '0;
            held_reg <= '0;
            pend_reg <= 1'b0;
            pair_reg <= '0;
            stop_reg <= 1'b0;
            sbad_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            // a direction write starts a fresh string
            dir_reg  <= cfg_data;
            lead_reg <= '0;
            cnt_reg  <= '0;
            part_reg <= '0;
            held_reg <= '0;
            pend_reg <= 1'b0;
            pair_reg <= '0;
            stop_reg <= 1'b0;
            sbad_reg <= 1'b0;
        end
        else if (take)
        begin
            lead_reg <= lead_next;
            cnt_reg  <= cnt_next;
            part_reg <= part_next;
            held_reg <= held_next;
            pend_reg <= pend_next;
            pair_reg <= pair_next;
            stop_reg <= stop_next;
            sbad_reg <= sbad_next;
        end
    end

endmodule

// ===== rtl/utjt_fifo.sv =====
// Short job queue between the front end and the byte emitter.
module utjt_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  utjt_pkg::job_t push_data,
    input  logic           pop,
    output utjt_pkg::job_t pop_data,
    output logic           empty,
    output logic           full
);
    import utjt_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign empty    = count_reg == '0;
    assign full     = count_reg == (QPTR_W+1)'(QDEPTH);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/utjt_back.sv =====
// Back end: turns the head job into output bytes, one per cycle unless stalled.
module utjt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  utjt_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           byte_valid,
    output logic           string_end,
    output logic           bad_coding
);
    import utjt_pkg::*;

    logic            out_valid_reg;
    logic [2:0]      idx_reg;
    logic [7:0]      out_byte_reg;
    logic            byte_valid_reg;
    logic            string_end_reg;
    logic            bad_coding_reg;

    enc_t            main_enc;
    enc_t            pre_enc;
    logic [7:0][7:0] list;
    logic [2:0]      total;
    logic [2:0]      eff;
    logic            marker;
    logic            final_b;
    logic            advance;
    logic            load;

    always_comb
    begin
        main_enc = head.main_java ? encode_java(head.main_code)
                                  : encode_utf8(head.main_code);
        if (!head.main_valid)
            main_enc = '0;
        pre_enc = encode_utf8({5'd0, head.pre_code});
        list    = '0;
        if (head.pre_valid)
        begin
            // a flushed surrogate is followed by at most three more bytes
            list[2:0] = pre_enc.bytes[2:0];
            list[5:3] = main_enc.bytes[2:0];
            total     = 3'd3 + ((main_enc.cnt > 3'd3) ? 3'd3 : main_enc.cnt);
        end
        else
        begin
            list[5:0] = main_enc.bytes;
            total     = main_enc.cnt;
        end
        marker = total == 3'd0;
        eff    = (marker && head.last) ? 3'd1 : total;
    end

    assign final_b = idx_reg == eff - 3'd1;
    assign advance = !out_valid_reg || !out_stall;
    assign load    = !empty && advance && eff != 3'd0;
    assign pop     = !empty && advance && (eff == 3'd0 || final_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= load;
            if (load)
                idx_reg <= final_b ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= list[idx_reg];
            byte_valid_reg <= !marker;
            string_end_reg <= head.last && final_b;
            bad_coding_reg <= head.last && head.bad;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign string_end = string_end_reg;
    assign bad_coding = bad_coding_reg;

endmodule
